// ----- rtl/core/tdps_pkg.sv -----
// Shared widths, types and state codes of the tick-driven priority task scheduler.
`default_nettype none

package tdps_pkg;

	localparam int TASK_W         = 3;
	localparam int PRIO_W         = 8;
	localparam int REG_IDX_W      = 3;
	localparam int NUM_PRIO_REGS  = 7;
	localparam int TASK_COUNT_DEF = 8;

	localparam logic [PRIO_W-1:0] PRIO_RESET = PRIO_W'(1);
	localparam logic [PRIO_W-1:0] SLICE_MAX  = {PRIO_W{1'b1}};

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_REFILL = 4'b0100,
		ST_DONE   = 4'b1000
	} state_t;

	typedef struct packed {
		logic dec;
		logic refill;
		logic prio_we;
	} cell_ctrl_t;

	typedef struct packed {
		logic              valid;
		logic [TASK_W-1:0] idx;
		logic [PRIO_W-1:0] cnt;
	} scan_t;

endpackage

`default_nettype wire

// ----- rtl/core/tdps_cell.sv -----
// One task cell: slice counter, priority register and one registered step of the max scan.
`default_nettype none

module tdps_cell import tdps_pkg::*; #(
	parameter int TASK_ID = 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cell_ctrl_t        ctrl,
	input  wire logic [PRIO_W-1:0] prio_wdata,
	input  wire scan_t             scan_in,
	output scan_t                  scan_out,
	output logic      [PRIO_W-1:0] count
);

	logic [PRIO_W-1:0] count_q;
	logic [PRIO_W-1:0] prio_q;
	scan_t             scan_q;
	logic [PRIO_W:0]   refill_sum;

	assign refill_sum = {2'b00, count_q[PRIO_W-1:1]} + {1'b0, prio_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			prio_q  <= PRIO_RESET;
			scan_q  <= '0;
		end else begin
			if (ctrl.prio_we) begin
				prio_q <= prio_wdata;
			end
			if (ctrl.refill) begin
				count_q <= refill_sum[PRIO_W] ? SLICE_MAX : refill_sum[PRIO_W-1:0];
			end else if (ctrl.dec) begin
				count_q <= count_q - PRIO_W'(1);
			end
			scan_q.valid <= scan_in.valid;
			if (scan_in.valid) begin
				if (count_q > scan_in.cnt) begin
					scan_q.idx <= TASK_W'(TASK_ID);
					scan_q.cnt <= count_q;
				end else begin
					scan_q.idx <= scan_in.idx;
					scan_q.cnt <= scan_in.cnt;
				end
			end
		end
	end

	assign scan_out = scan_q;
	assign count    = count_q;

endmodule

`default_nettype wire

// ----- rtl/core/tick_driven_priority_task_scheduler.sv -----
// Top level of the tick-driven priority task scheduler: task cell chain and control sequencer.
//
// Channel  Direction  Handshake                   Word
// tick     in         tick_valid / tick_ready     tick
// result   out        result_valid / result_ready running_task, switched, counters_refilled,
//                                                 remaining_slice, no_runnable_work
// config   in         wr_en (no wait)             wr_index, wr_data
//
// A tick that is low or that only decrements the running task's slice goes from ST_IDLE straight to ST_DONE.
// A reschedule walks the max scan down the chain of TASK_COUNT-1 cells, one cell per cycle,
// and when all counters must be refilled, refills them and walks the scan a second time.
// Reset clears all slice counters, selects the idle task and sets every priority to 1.
// A finished word waits in the output register; a new tick is taken meanwhile and held
// at its end until the output register frees up.
`default_nettype none

module tick_driven_priority_task_scheduler import tdps_pkg::*; #(
	parameter int TASK_COUNT = TASK_COUNT_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire logic [REG_IDX_W-1:0] wr_index,
	input  wire logic    [PRIO_W-1:0] wr_data,
	input  wire logic                 tick_valid,
	output logic                      tick_ready,
	input  wire logic                 tick,
	output logic                      result_valid,
	input  wire logic                 result_ready,
	output logic         [TASK_W-1:0] running_task,
	output logic                      switched,
	output logic                      counters_refilled,
	output logic         [PRIO_W-1:0] remaining_slice,
	output logic                      no_runnable_work
);

	localparam int IDX_W = (TASK_COUNT > 2) ? $clog2(TASK_COUNT) : 1;
	localparam int SLOTS = 1 << IDX_W;

	state_t            state_q, state_d;
	logic [TASK_W-1:0] cur_task_q;
	logic              refilled_q;
	scan_t             link [TASK_COUNT];
	logic [PRIO_W-1:0] counts [SLOTS];
	logic [PRIO_W-1:0] slice_cur;
	logic              start, dec_en, refill_en, load_res, load_out;

	logic [TASK_W-1:0] n_task;
	logic              n_sw, n_ref, n_none;
	logic [PRIO_W-1:0] n_slice;
	logic [TASK_W-1:0] res_task_q;
	logic              res_sw_q, res_ref_q, res_none_q;
	logic [PRIO_W-1:0] res_slice_q;

	logic              result_valid_q;
	logic [TASK_W-1:0] running_task_q;
	logic              switched_q, counters_refilled_q, no_runnable_work_q;
	logic [PRIO_W-1:0] remaining_slice_q;

	assign link[0].valid = start;
	assign link[0].idx   = '0;
	assign link[0].cnt   = '0;
	assign counts[0]     = '0;

	for (genvar k = 1; k < TASK_COUNT; k++) begin : g_cell
		cell_ctrl_t ctrl;

		assign ctrl.dec     = dec_en && (cur_task_q == TASK_W'(k));
		assign ctrl.refill  = refill_en;
		assign ctrl.prio_we = wr_en && (wr_index == REG_IDX_W'(k - 1));

		tdps_cell #(
			.TASK_ID (k)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.prio_wdata (wr_data),
			.scan_in    (link[k-1]),
			.scan_out   (link[k]),
			.count      (counts[k])
		);
	end

	for (genvar k = TASK_COUNT; k < SLOTS; k++) begin : g_pad
		assign counts[k] = '0;
	end

	assign slice_cur  = counts[cur_task_q[IDX_W-1:0]];
	assign tick_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d   = state_q;
		start     = 1'b0;
		dec_en    = 1'b0;
		refill_en = 1'b0;
		load_res  = 1'b0;
		load_out  = 1'b0;
		n_task    = cur_task_q;
		n_sw      = 1'b0;
		n_ref     = 1'b0;
		n_slice   = slice_cur;
		n_none    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (tick_valid) begin
					if (!tick) begin
						load_res = 1'b1;
						state_d  = ST_DONE;
					end else if (cur_task_q != '0 && slice_cur != '0) begin
						dec_en   = 1'b1;
						load_res = 1'b1;
						n_slice  = slice_cur - PRIO_W'(1);
						state_d  = ST_DONE;
					end else begin
						start   = 1'b1;
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (link[TASK_COUNT-1].valid) begin
					if (link[TASK_COUNT-1].idx != '0) begin
						load_res = 1'b1;
						n_task   = link[TASK_COUNT-1].idx;
						n_sw     = (link[TASK_COUNT-1].idx != cur_task_q);
						n_ref    = refilled_q;
						n_slice  = link[TASK_COUNT-1].cnt;
						state_d  = ST_DONE;
					end else if (!refilled_q) begin
						refill_en = 1'b1;
						state_d   = ST_REFILL;
					end else begin
						load_res = 1'b1;
						n_none   = 1'b1;
						state_d  = ST_DONE;
					end
				end
			end
			ST_REFILL: begin
				start   = 1'b1;
				state_d = ST_SCAN;
			end
			ST_DONE: begin
				if (!result_valid_q || result_ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			cur_task_q     <= '0;
			refilled_q     <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_res) begin
				cur_task_q <= n_task;
			end
			if (state_q == ST_IDLE) begin
				refilled_q <= 1'b0;
			end else if (refill_en) begin
				refilled_q <= 1'b1;
			end
			if (load_out) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			res_task_q  <= n_task;
			res_sw_q    <= n_sw;
			res_ref_q   <= n_ref;
			res_slice_q <= n_slice;
			res_none_q  <= n_none;
		end
		if (load_out) begin
			running_task_q      <= res_task_q;
			switched_q          <= res_sw_q;
			counters_refilled_q <= res_ref_q;
			remaining_slice_q   <= res_slice_q;
			no_runnable_work_q  <= res_none_q;
		end
	end

	assign result_valid      = result_valid_q;
	assign running_task      = running_task_q;
	assign switched          = switched_q;
	assign counters_refilled = counters_refilled_q;
	assign remaining_slice   = remaining_slice_q;
	assign no_runnable_work  = no_runnable_work_q;

`ifndef SYNTHESIS
	a_task_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, cur_task_q} < (TASK_W + 1)'(TASK_COUNT))
		else $error("running task index beyond the task count");

	a_scan_only_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		link[TASK_COUNT-1].valid |-> state_q == ST_SCAN)
		else $error("scan result arrived outside the scan state");

	a_refill_then_scan: assert property (@(posedge clk) disable iff (!arst_n)
		refill_en |=> state_q == ST_REFILL && refilled_q)
		else $error("refill not followed by a second scan");

	a_none_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(no_runnable_work && (switched || counters_refilled)))
		else $error("no_runnable_work together with a switch or refill");

	a_switch_not_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && switched |-> running_task != '0)
		else $error("switch reported to the idle task");
`endif

endmodule

`default_nettype wire
